>>> design/fsq_pkg.sv
`default_nettype none

package fsq_pkg;

    // Fixed field widths
    localparam int unsigned SIZE_W   = 32;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W    = 5;

    // Default queue depth
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Operation codes
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_DEQUEUE = 1'b1;

    // Scheduling policy codes
    localparam logic POLICY_FIFO   = 1'b0;
    localparam logic POLICY_SORTED = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] req_size;
        logic [TAG_W-1:0]  request_tag;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   out_size;
        logic [TAG_W-1:0]    out_tag;
        logic [OCC_W-1:0]    occupancy;
    } resp_item_t;

    // Read address select
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_SRC,
        RD_SRC_NEXT
    } rd_sel_t;

    // Write address and data select
    typedef enum logic [1:0] {
        WR_TAIL_NEW,
        WR_DST_NEW,
        WR_DST_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    k_dec;
        logic    finish;
    } dp_cmd_t;

    typedef struct packed {
        logic func_deq;
        logic full;
        logic empty;
        logic policy_sorted;
        logic size_gt;
        logic k_one;
    } dp_status_t;

endpackage

`default_nettype wire

>>> design/fsq_datapath.sv
`default_nettype none

module fsq_datapath #(
    parameter int unsigned DEPTH = fsq_pkg::DEPTH_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  fsq_pkg::req_item_t  s_payload,
    input  wire                 cfg_we,
    input  wire                 cfg_data,
    input  fsq_pkg::dp_cmd_t    cmd,
    output fsq_pkg::dp_status_t status,
    output fsq_pkg::resp_item_t m_payload
);
    import fsq_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [TAG_W-1:0]  tag;
    } mem_entry_t;

    // Fold a sum below twice the depth back into the index range
    function automatic logic [PW-1:0] wrap_idx(input logic [SW-1:0] v);
        logic [SW-1:0] r;
        r = (v >= SW'(DEPTH)) ? (v - SW'(DEPTH)) : v;
        return r[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] inc_idx(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : (p + 1'b1);
    endfunction

    mem_entry_t mem [DEPTH];

    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              policy_reg;
    logic [CW-1:0]     k_reg;
    logic              item_func_reg;
    logic [SIZE_W-1:0] item_size_reg;
    logic [TAG_W-1:0]  item_tag_reg;
    mem_entry_t        rd_data_reg;
    resp_item_t        m_payload_reg, m_payload_next;

    logic [PW-1:0] src_idx, src_next_idx, dst_idx;
    logic [PW-1:0] raddr, waddr;
    mem_entry_t    wdata;
    logic [SW-1:0] head_ext, k_ext;

    // Scan positions relative to the head
    assign head_ext     = SW'(head_reg);
    assign k_ext        = SW'(k_reg);
    assign dst_idx      = wrap_idx(head_ext + k_ext);
    assign src_idx      = wrap_idx(head_ext + k_ext - SW'(1));
    assign src_next_idx = wrap_idx(head_ext + k_ext - SW'(2));

    // Select read address
    always_comb begin
        unique case (cmd.rd_sel)
            RD_HEAD:     raddr = head_reg;
            RD_SRC:      raddr = src_idx;
            RD_SRC_NEXT: raddr = src_next_idx;
            default:     raddr = head_reg;
        endcase
    end

    // Select write address and data
    always_comb begin
        unique case (cmd.wr_sel)
            WR_TAIL_NEW: begin
                waddr = tail_reg;
                wdata = '{size: item_size_reg, tag: item_tag_reg};
            end
            WR_DST_NEW: begin
                waddr = dst_idx;
                wdata = '{size: item_size_reg, tag: item_tag_reg};
            end
            WR_DST_SHIFT: begin
                waddr = dst_idx;
                wdata = rd_data_reg;
            end
            default: begin
                waddr = tail_reg;
                wdata = '{size: item_size_reg, tag: item_tag_reg};
            end
        endcase
    end

    // Entry store with registered read
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Status toward the controller
    assign status.func_deq      = (item_func_reg == FUNC_DEQUEUE);
    assign status.full          = (count_reg == CW'(DEPTH));
    assign status.empty         = (count_reg == '0);
    assign status.policy_sorted = (policy_reg == POLICY_SORTED);
    assign status.size_gt       = (rd_data_reg.size > item_size_reg);
    assign status.k_one         = (k_reg == CW'(1));

    // Retire the item: build the result and advance the pointers
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        m_payload_next = m_payload_reg;
        if (cmd.finish) begin
            m_payload_next.out_size = '0;
            m_payload_next.out_tag  = '0;
            if (item_func_reg == FUNC_DEQUEUE) begin
                if (status.empty) begin
                    m_payload_next.status = STATUS_EMPTY;
                end else begin
                    m_payload_next.status   = STATUS_DONE;
                    m_payload_next.out_size = rd_data_reg.size;
                    m_payload_next.out_tag  = rd_data_reg.tag;
                    head_next               = inc_idx(head_reg);
                    count_next              = count_reg - 1'b1;
                end
            end else begin
                if (status.full) begin
                    m_payload_next.status = STATUS_FULL;
                end else begin
                    m_payload_next.status = STATUS_DONE;
                    tail_next             = inc_idx(tail_reg);
                    count_next            = count_reg + 1'b1;
                end
            end
            m_payload_next.occupancy = OCC_W'(count_next);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            policy_reg <= POLICY_FIFO;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cfg_we) begin
                policy_reg <= cfg_data;
            end
        end
    end

    // Item and result registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_func_reg <= s_payload.func;
            item_size_reg <= s_payload.req_size;
            item_tag_reg  <= s_payload.request_tag;
            k_reg         <= count_reg;
        end else if (cmd.k_dec) begin
            k_reg <= k_reg - 1'b1;
        end
        m_payload_reg <= m_payload_next;
    end

    assign m_payload = m_payload_reg;

    logic [PW-1:0] tail_chk;
    assign tail_chk = wrap_idx(head_ext + SW'(count_reg));

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_tail_follows_head: assert property (@(posedge aclk) disable iff (!aresetn)
        tail_chk == tail_reg)
        else $error("tail pointer out of step with head and count");

    a_no_port_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.rd_en) |-> (waddr != raddr))
        else $error("read and write at the same entry");

endmodule

`default_nettype wire

>>> design/fsq_controller.sv
`default_nettype none

module fsq_controller (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  wire                 m_ready,
    input  fsq_pkg::dp_status_t status,
    output fsq_pkg::dp_cmd_t    cmd
);
    import fsq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_PLACE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Accept only when the result slot is free or drains this cycle
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '{load_item: 1'b0, rd_en: 1'b0, rd_sel: RD_HEAD,
                         wr_en: 1'b0, wr_sel: WR_TAIL_NEW, k_dec: 1'b0,
                         finish: 1'b0};
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (status.func_deq) begin
                    // Fetch the head entry; rejected dequeue ignores it
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_HEAD;
                    state_next = ST_RESP;
                end else if (status.full) begin
                    state_next = ST_RESP;
                end else if (!status.policy_sorted) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_TAIL_NEW;
                    state_next = ST_RESP;
                end else if (status.empty) begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DST_NEW;
                    state_next = ST_RESP;
                end else begin
                    // Start the scan at the youngest entry
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SRC;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.size_gt) begin
                    // Shift the larger entry up one slot, read the next one down
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DST_SHIFT;
                    cmd.k_dec  = 1'b1;
                    if (status.k_one) begin
                        state_next = ST_PLACE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_SRC_NEXT;
                    end
                end else begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_DST_NEW;
                    state_next = ST_RESP;
                end
            end
            ST_PLACE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_DST_NEW;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                cmd.finish   = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside the retire step");

    a_accept_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid_reg || m_ready))
        else $error("transaction accepted while result slot is blocked");

    a_resp_slot_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP) |-> !m_valid_reg)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> design/fifo_or_size_sorted_request_queue_core.sv
`default_nettype none

// Bounded request queue of DEPTH entries (file size and tag). An enqueue
// transaction appends at the tail when sched_policy is 0, or, when it is 1,
// inserts the entry after every held entry of equal or smaller size. A
// dequeue always removes the head entry. A full enqueue or an empty dequeue
// is rejected with a status code and leaves the queue unchanged. Each
// transaction gives exactly one result carrying the occupancy after it.
// One transaction is in work at a time. Dequeue, rejected operations,
// first-come enqueue and a sorted enqueue into an empty queue pass decode
// and retire steps; any other sorted enqueue adds one scan step for each
// of the n (1 to DEPTH-1) held entries it compares, plus a place step when
// every held entry is larger, since the insert scan reads and moves one
// entry per cycle through the store's one read and one write port. A new
// transaction is accepted once idle with the result slot free or draining.
// The user must write sched_policy only while the queue is idle; the block
// itself does not enforce it. cfg_ready is always high.

module fifo_or_size_sorted_request_queue_core #(
    parameter int unsigned DEPTH = fsq_pkg::DEPTH_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  fsq_pkg::req_item_t  s_payload,
    output logic                m_valid,
    input  wire                 m_ready,
    output fsq_pkg::resp_item_t m_payload,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data
);
    import fsq_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fsq_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fsq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

>>> test/request_queue_checker.sv
module request_queue_checker #(
    parameter int unsigned DEPTH = fsq_pkg::DEPTH_DEFAULT
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  fsq_pkg::req_item_t  s_payload,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  fsq_pkg::resp_item_t m_payload,
    input  wire                 cfg_valid,
    input  wire                 cfg_ready,
    input  wire                 cfg_data,
    output int unsigned         mismatch_count,
    output int unsigned         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsq_pkg::*;

    // Shadow copy of the circular entry store
    logic [SIZE_W-1:0] slot_size [DEPTH];
    logic [TAG_W-1:0]  slot_tag  [DEPTH];
    int unsigned       head_idx = 0;
    int unsigned       tail_idx = 0;
    int unsigned       held     = 0;
    logic              policy   = POLICY_FIFO;

    resp_item_t        due_responses [$];
    int unsigned       failures     = 0;
    int unsigned       pending      = 0;
    int unsigned       result_index = 0;

    assign mismatch_count = failures;
    assign outstanding    = pending;

    function automatic int unsigned wrap(input int unsigned v);
        return v % DEPTH;
    endfunction

    // Apply one request transaction to the shadow queue and return its result
    function automatic resp_item_t serve_request(input req_item_t req);
        resp_item_t  resp;
        int unsigned k;
        resp = '0;
        resp.status = STATUS_DONE;
        if (req.func == FUNC_ENQUEUE) begin
            if (held >= DEPTH) begin
                resp.status = STATUS_FULL;
            end else if (policy == POLICY_FIFO) begin
                slot_size[tail_idx] = req.req_size;
                slot_tag[tail_idx]  = req.request_tag;
            end else begin
                // move strictly larger entries up one slot, scanning back from the newest
                k = held;
                while (k > 0 && slot_size[wrap(head_idx + k - 1)] > req.req_size) begin
                    slot_size[wrap(head_idx + k)] = slot_size[wrap(head_idx + k - 1)];
                    slot_tag[wrap(head_idx + k)]  = slot_tag[wrap(head_idx + k - 1)];
                    k--;
                end
                slot_size[wrap(head_idx + k)] = req.req_size;
                slot_tag[wrap(head_idx + k)]  = req.request_tag;
            end
            if (resp.status == STATUS_DONE) begin
                tail_idx = wrap(tail_idx + 1);
                held++;
            end
        end else if (held == 0) begin
            resp.status = STATUS_EMPTY;
        end else begin
            resp.out_size = slot_size[head_idx];
            resp.out_tag  = slot_tag[head_idx];
            head_idx = wrap(head_idx + 1);
            held--;
        end
        resp.occupancy = held[OCC_W-1:0];
        return resp;
    endfunction

    // Count a failure, report only the first few
    task automatic flag_mismatch(input string what);
        failures++;
        if (failures <= 10) begin
            $display("mismatch at result %0d: %s", result_index, what);
        end
    endtask

    // Watch all three channels at the rising edge
    always @(posedge aclk) begin : watch_channels
        resp_item_t want;
        if (!aresetn) begin
            head_idx = 0;
            tail_idx = 0;
            held     = 0;
            policy   = POLICY_FIFO;
            due_responses.delete();
        end else begin
            // compare a result transaction with the oldest prediction
            if (m_valid && m_ready) begin
                if (due_responses.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %h", m_payload));
                end else begin
                    want = due_responses.pop_front();
                    if (m_payload.status !== want.status)
                        flag_mismatch($sformatf("status expected %0d got %0d",
                                                want.status, m_payload.status));
                    if (m_payload.out_size !== want.out_size)
                        flag_mismatch($sformatf("out_size expected %h got %h",
                                                want.out_size, m_payload.out_size));
                    if (m_payload.out_tag !== want.out_tag)
                        flag_mismatch($sformatf("out_tag expected %h got %h",
                                                want.out_tag, m_payload.out_tag));
                    if (m_payload.occupancy !== want.occupancy)
                        flag_mismatch($sformatf("occupancy expected %0d got %0d",
                                                want.occupancy, m_payload.occupancy));
                end
                result_index++;
            end
            // track the policy register
            if (cfg_valid && cfg_ready) begin
                policy = cfg_data;
            end
            // predict the result of a request transaction
            if (s_valid && s_ready) begin
                due_responses.push_back(serve_request(s_payload));
            end
        end
        pending = due_responses.size();
    end

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsq_pkg::*;

    localparam int unsigned DEPTH       = DEPTH_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 110;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    req_item_t  s_payload = '0;
    logic       s_ready;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    resp_item_t m_payload;
    logic       cfg_valid = 1'b0;
    logic       cfg_data  = 1'b0;
    logic       cfg_ready;

    int unsigned mismatch_count;
    int unsigned outstanding;

    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned cycle_count  = 0;

    logic [SIZE_W-1:0] corner_sizes [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                            32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA,
                                            32'h5555_5555, 32'h0000_0005};
    logic        phase_policy [PHASES] = '{POLICY_SORTED, POLICY_FIFO, POLICY_SORTED,
                                           POLICY_SORTED, POLICY_FIFO, POLICY_SORTED,
                                           POLICY_FIFO, POLICY_SORTED};
    int unsigned enq_pct [PHASES] = '{75, 30, 55, 80, 25, 50, 70, 40};

    fifo_or_size_sorted_request_queue_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    request_queue_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Drive result ready: random stalls, calm stretches and one long hold-off
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (calm) begin
            m_ready = 1'b1;
        end else begin
            m_ready = ($urandom_range(99) >= 10);
        end
    end

    // Offer one request transaction and hold it until accepted
    task automatic offer(input logic func, input logic [SIZE_W-1:0] size,
                         input logic [TAG_W-1:0] tag);
        int unsigned gap;
        if (!calm && $urandom_range(99) < 10) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(negedge aclk);
        end
        s_payload.func        = func;
        s_payload.req_size    = size;
        s_payload.request_tag = tag;
        s_valid               = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        s_valid = 1'b0;
        wait (outstanding == 0);
        @(negedge aclk);
    endtask

    // Write the policy register while the queue is idle
    task automatic set_policy(input logic value);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Size mix: many small ties, the extremes, and full-range values
    function automatic logic [SIZE_W-1:0] draw_size();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 35) return $urandom_range(7);
        if (pick < 45) return '0;
        if (pick < 55) return '1;
        return $urandom;
    endfunction

    initial begin
        int unsigned       i;
        int unsigned       phase;
        int unsigned       n;
        logic [TAG_W-1:0]  tag;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        set_policy(POLICY_FIFO);

        // dequeue from an empty queue
        offer(FUNC_DEQUEUE, '1, '1);
        // fill with corner sizes and tags
        for (i = 0; i < DEPTH; i++) begin
            tag = i[TAG_W-1:0];
            if (i % 2 == 1) tag = ~tag;
            offer(FUNC_ENQUEUE, (i < 8) ? corner_sizes[i] : SIZE_W'(i * 3), tag);
        end
        // enqueue into a full queue
        offer(FUNC_ENQUEUE, 32'h0000_1234, 16'h1234);
        // drain a few in arrival order
        for (i = 0; i < 3; i++) begin
            offer(FUNC_DEQUEUE, '0, '0);
        end
        // switch to sorted with entries held, then insert ties and a minimum
        set_policy(POLICY_SORTED);
        offer(FUNC_ENQUEUE, 32'h0000_0005, 16'h00A1);
        offer(FUNC_ENQUEUE, 32'h0000_0005, 16'h00A2);
        offer(FUNC_ENQUEUE, 32'h0000_0000, 16'h00A3);

        // random phases with a drifting fill level
        for (phase = 0; phase < PHASES; phase++) begin
            set_policy(phase_policy[phase]);
            calm = (phase == 2);
            if (phase == 4) hold_request = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < enq_pct[phase])
                    offer(FUNC_ENQUEUE, draw_size(), TAG_W'($urandom));
                else
                    offer(FUNC_DEQUEUE, draw_size(), TAG_W'($urandom));
            end
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
